// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with asynchronous reset qualification.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: sv/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Types and constants of the header/tail frame extractor.
// ----------------------------------------------------------------------------
package hte_pkg;

	localparam logic [7:0]  HEADER_RESET = 8'hEE;
	localparam logic [31:0] TAIL_RESET   = 32'hFFFCFFFF;
	localparam int unsigned TAIL_BYTES   = 4;

	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_TAIL   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} hte_state_t;

endpackage

// File: sv/header_tail_frame_extractor.sv
// The first frame word is offered after ST_EMIT has read it into rd_data_q.
// Throughput: one input word per cycle while no frame is being delivered; a frame of
// N words then blocks input until all are read, one ring memory read per output word.
// The single-port ring read gives one word per cycle while out_ready stays high.
// Reset: asynchronous, active low; pointers and sequencer are cleared, the registers
// return to their reset values, the ring contents are left as they are.
// ----------------------------------------------------------------------------
// header_tail_frame_extractor
// Stores received bytes in a ring, detects header/tail framed messages and
// delivers each complete frame from the ring, marking its final word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module header_tail_frame_extractor #(
	parameter int RING_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        is_last
);
	import hte_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
	localparam logic [AW:0]   TAIL_W   = (AW + 1)'(TAIL_BYTES);

	logic [7:0]    ring [RING_DEPTH];
	logic [7:0]    header_q;
	logic [31:0]   tail_pat_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] fsp_q;
	logic [7:0]    first_q;
	logic [31:0]   recent_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] cnt_q;
	logic [7:0]    rd_data_q;
	logic          last_q;
	logic          out_valid_q;
	hte_state_t    state_q;

	logic          in_acc;
	logic          cfg_wr;
	logic          rd_en;
	logic [AW-1:0] wp_next;
	logic [AW-1:0] rd_ptr_next;
	logic [31:0]   recent_next;
	logic [7:0]    first_eff;
	logic [AW:0]   held;
	logic          tail_hit;

	assign pready    = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign out_valid = out_valid_q;
	assign frame_byte = rd_data_q;
	assign is_last   = last_q;

	assign prdata = (paddr[2] == REG_TAIL) ? tail_pat_q : {24'd0, header_q};

	assign wp_next     = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
	assign rd_ptr_next = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
	assign recent_next = {recent_q[23:0], rx_byte};
	assign first_eff   = (fsp_q == wp_q) ? rx_byte : first_q;
	assign held = (wp_next >= fsp_q) ? ({1'b0, wp_next} - {1'b0, fsp_q})
		: ({1'b0, wp_next} + DEPTH_W - {1'b0, fsp_q});
	assign tail_hit = (held >= TAIL_W) && (recent_next == tail_pat_q);
	assign rd_en = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring[wp_q] <= rx_byte;
		end
		if (rd_en) begin
			rd_data_q <= ring[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= HEADER_RESET;
			tail_pat_q <= TAIL_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_HEADER: header_q   <= pwdata[7:0];
				REG_TAIL:   tail_pat_q <= pwdata;
				default:    header_q   <= header_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fsp_q       <= '0;
			first_q     <= '0;
			recent_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= ST_IDLE;
		end else begin
			if (rd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wp_q     <= wp_next;
						recent_q <= recent_next;
						first_q  <= first_eff;
						if (first_eff != header_q) begin
							fsp_q <= wp_next;
						end else if (tail_hit) begin
							rd_ptr_q <= fsp_q;
							cnt_q    <= held[AW-1:0];
							fsp_q    <= wp_next;
							state_q  <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						last_q   <= (cnt_q == AW'(1));
						rd_ptr_q <= rd_ptr_next;
						cnt_q    <= cnt_q - 1'b1;
						if (cnt_q == AW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_out_from_emit, clk, arst_n, $rose(out_valid) |-> $past(state_q == ST_EMIT), "output word appeared outside frame delivery")
	`ASSERT_NEVER(a_emit_cnt_zero, clk, arst_n, (state_q == ST_EMIT) && (cnt_q == '0), "frame delivery with no words left")
	`ASSERT_CLK(a_emit_idle_ptrs, clk, arst_n, (state_q == ST_EMIT) |-> (fsp_q == wp_q), "frame start not rearmed during delivery")

endmodule
